// File: src/rmts_pkg.sv
// Package: shared types and constants for the rate-monotonic thread scheduler.
package rmts_pkg;

    localparam int THREAD_SLOTS_DEF = 8;
    localparam int PERIOD_W         = 16;
    localparam logic [3:0] IDLE_THREAD = 4'd8;

    typedef enum logic [1:0] {
        CMD_CREATE   = 2'd0,
        CMD_ACTIVATE = 2'd1,
        CMD_SUSPEND  = 2'd2,
        CMD_DISPATCH = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STS_OK     = 2'd0,
        STS_FULL   = 2'd1,
        STS_UNUSED = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        SLOT_UNUSED    = 2'd0,
        SLOT_ACTIVE    = 2'd1,
        SLOT_SUSPENDED = 2'd2
    } t_slot_st;

    typedef struct packed {
        t_cmd                  cmd;
        logic [2:0]            thread_id;
        logic [PERIOD_W-1:0]   period;
    } t_in_word;

    typedef struct packed {
        logic [2:0] new_slot;
        t_status    status;
        logic [3:0] next_thread;
    } t_out_word;

endpackage

// File: src/rmts_period_mem.sv
// Period table: synchronous memory, one write and one registered read port.
module rmts_period_mem #(
    parameter int DEPTH = rmts_pkg::THREAD_SLOTS_DEF,
    parameter int AW    = $clog2(rmts_pkg::THREAD_SLOTS_DEF)
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [AW-1:0]                 i_waddr,
    input  logic [rmts_pkg::PERIOD_W-1:0] i_wdata,
    input  logic [AW-1:0]                 i_raddr,
    output logic [rmts_pkg::PERIOD_W-1:0] o_rdata
);

    logic [rmts_pkg::PERIOD_W-1:0] r_mem [DEPTH];
    logic [rmts_pkg::PERIOD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/rate_monotonic_thread_scheduler.sv
// Top level: rate-monotonic thread scheduler with command sequencer and priority scan.
// One command word in, one result word out. A command passes through the states
// EXEC, SCAN, LAST and DONE: EXEC updates the slot table, SCAN reads each slot in turn
// from the period memory, whose registered read adds a compare step (LAST covers the
// last slot's compare), and DONE loads the result register once it is free. The input
// is stalled from acceptance until the result is loaded, so a command is not taken
// before the previous one is through; a finished result waits in DONE while the
// output register is held. A new command is accepted while the previous result still
// waits downstream. The slot with the smallest period among active slots wins, lower
// slot on ties; with none active the result is 8, the idle thread.
module rate_monotonic_thread_scheduler #(
    parameter int THREAD_SLOTS = rmts_pkg::THREAD_SLOTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  rmts_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output rmts_pkg::t_out_word o_out_word
);

    localparam int IW = $clog2(THREAD_SLOTS);
    localparam logic [IW-1:0] LAST_SLOT = IW'(THREAD_SLOTS - 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_SCAN = 5'b00100,
        S_LAST = 5'b01000,
        S_DONE = 5'b10000
    } t_fsm;

    t_fsm                          r_fsm, n_fsm;
    rmts_pkg::t_slot_st            r_slot_st [THREAD_SLOTS];
    rmts_pkg::t_in_word            r_in;
    logic [IW-1:0]                 r_k;
    logic                          r_cmp_valid;
    logic [IW-1:0]                 r_cmp_k;
    logic                          r_found, n_found;
    logic [IW-1:0]                 r_best, n_best;
    logic [rmts_pkg::PERIOD_W-1:0] r_best_per, n_best_per;
    logic [2:0]                    r_new_slot;
    rmts_pkg::t_status             r_status;
    logic                          r_out_valid;
    rmts_pkg::t_out_word           r_out;

    logic                          free_found;
    logic [IW-1:0]                 free_idx;
    logic                          tid_ok;
    logic                          mem_we;
    logic [rmts_pkg::PERIOD_W-1:0] rd_per;
    logic                          have_best;
    logic                          out_free;
    logic                          in_acc;

    assign in_acc     = i_in_valid && (r_fsm == S_IDLE);
    assign o_in_stall = (r_fsm != S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int k = 0; k < THREAD_SLOTS; k++) begin
            if (!free_found && r_slot_st[k] == rmts_pkg::SLOT_UNUSED) begin
                free_found = 1'b1;
                free_idx   = IW'(k);
            end
        end
    end

    assign tid_ok = (int'(r_in.thread_id) < THREAD_SLOTS) &&
                    (r_slot_st[IW'(r_in.thread_id)] != rmts_pkg::SLOT_UNUSED);

    assign mem_we = (r_fsm == S_EXEC) && (r_in.cmd == rmts_pkg::CMD_CREATE) && free_found;

    rmts_period_mem #(
        .DEPTH (THREAD_SLOTS),
        .AW    (IW)
    ) u_period_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (free_idx),
        .i_wdata (r_in.period),
        .i_raddr (r_k),
        .o_rdata (rd_per)
    );

    // an index that aliases the idle code restarts the search, as the scan rule does
    assign have_best = r_found && (32'(r_best) != 32'd8);

    always_comb begin
        n_found    = r_found;
        n_best     = r_best;
        n_best_per = r_best_per;
        if (r_cmp_valid && r_slot_st[r_cmp_k] == rmts_pkg::SLOT_ACTIVE) begin
            if (!have_best || rd_per < r_best_per) begin
                n_found    = 1'b1;
                n_best     = r_cmp_k;
                n_best_per = rd_per;
            end
        end
        if (r_fsm == S_EXEC) begin
            n_found = 1'b0;
        end
    end

    always_comb begin
        n_fsm = r_fsm;
        unique case (r_fsm)
            S_IDLE: if (i_in_valid) n_fsm = S_EXEC;
            S_EXEC: n_fsm = S_SCAN;
            S_SCAN: if (r_k == LAST_SLOT) n_fsm = S_LAST;
            S_LAST: n_fsm = S_DONE;
            S_DONE: if (out_free) n_fsm = S_IDLE;
            default: n_fsm = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= S_IDLE;
            r_cmp_valid <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < THREAD_SLOTS; k++) begin
                r_slot_st[k] <= rmts_pkg::SLOT_UNUSED;
            end
        end else begin
            r_fsm       <= n_fsm;
            r_cmp_valid <= (r_fsm == S_SCAN);
            if (r_fsm == S_EXEC) begin
                unique case (r_in.cmd)
                    rmts_pkg::CMD_CREATE: begin
                        if (free_found) r_slot_st[free_idx] <= rmts_pkg::SLOT_ACTIVE;
                    end
                    rmts_pkg::CMD_ACTIVATE: begin
                        if (tid_ok) r_slot_st[IW'(r_in.thread_id)] <= rmts_pkg::SLOT_ACTIVE;
                    end
                    rmts_pkg::CMD_SUSPEND: begin
                        if (tid_ok) begin
                            r_slot_st[IW'(r_in.thread_id)] <= rmts_pkg::SLOT_SUSPENDED;
                        end
                    end
                    rmts_pkg::CMD_DISPATCH: ;
                    default: ;
                endcase
            end
            if (r_fsm == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_word;
        end
        r_cmp_k    <= r_k;
        r_found    <= n_found;
        r_best     <= n_best;
        r_best_per <= n_best_per;
        if (r_fsm == S_EXEC) begin
            r_k <= '0;
            unique case (r_in.cmd)
                rmts_pkg::CMD_CREATE: begin
                    r_new_slot <= free_found ? 3'(free_idx) : 3'd0;
                    r_status   <= free_found ? rmts_pkg::STS_OK : rmts_pkg::STS_FULL;
                end
                rmts_pkg::CMD_ACTIVATE, rmts_pkg::CMD_SUSPEND: begin
                    r_new_slot <= '0;
                    r_status   <= tid_ok ? rmts_pkg::STS_OK : rmts_pkg::STS_UNUSED;
                end
                rmts_pkg::CMD_DISPATCH: begin
                    r_new_slot <= '0;
                    r_status   <= rmts_pkg::STS_OK;
                end
                default: begin
                    r_new_slot <= '0;
                    r_status   <= rmts_pkg::STS_OK;
                end
            endcase
        end else if (r_fsm == S_SCAN) begin
            r_k <= r_k + 1'b1;
        end
        if (r_fsm == S_DONE && out_free) begin
            r_out.new_slot    <= r_new_slot;
            r_out.status      <= r_status;
            r_out.next_thread <= r_found ? 4'(r_best) : rmts_pkg::IDLE_THREAD;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule
